// File: design/picture_order_count_derive_core_defines.svh
// ============================================================================
// Assertion macros for the picture order count derivation core
// Shared property templates, clocked on the rising edge and disabled in reset.
// ============================================================================
`ifndef PICTURE_ORDER_COUNT_DERIVE_CORE_DEFINES_SVH
`define PICTURE_ORDER_COUNT_DERIVE_CORE_DEFINES_SVH

// Same-cycle implication: when ante holds, cons holds in that cycle.
`define POCD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication: when ante holds, cons holds in the next cycle.
`define POCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: design/pocd_pkg.sv
// ============================================================================
// pocd_pkg
// Types, register indexes and constants shared by the POC derivation core.
// ============================================================================
`default_nettype none

package pocd_pkg;

    // Default values of the top-level parameters.
    localparam int MAX_LOG2_SUB_GOP_DEF = 5;
    localparam int POC_WIDTH_DEF        = 32;

    // Configuration port shape and register indexes.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 5;

    localparam logic [CFG_INDEX_W-1:0] CFG_POC_LSB_MODE        = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOG2_MAX_POC_LSB    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOG2_SUB_GOP_LENGTH = 2'd2;

    // Configuration reset values.
    localparam logic       RST_POC_LSB_MODE        = 1'b0;
    localparam logic [4:0] RST_LOG2_MAX_POC_LSB    = 5'd8;
    localparam logic [2:0] RST_LOG2_SUB_GOP_LENGTH = 3'd3;

    // Legal range of the POC LSB modulus exponent.
    localparam logic [4:0] LSB_LOG2_MIN = 5'd4;
    localparam logic [4:0] LSB_LOG2_MAX = 5'd16;

    // Result status codes.
    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_TID_RANGE = 1'b1;

    // One input item: one coded picture.
    typedef struct packed {
        logic        is_idr;
        logic [15:0] poc_lsb;
        logic [2:0]  temporal_id;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic signed [31:0] poc_value;
        logic               status;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture the accepted item
        logic calc;    // update of the counts or offset search setup
        logic step;    // advance the decode offset by one position
        logic finish;  // apply the offset formula to the anchor
        logic push;    // move the result into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic one_step;  // item completes in the calc cycle
        logic found;     // offset search reached its answer
    } t_dp_status;

endpackage

`default_nettype wire

// File: design/picture_order_count_derive_core.sv
// ============================================================================
// picture_order_count_derive_core
// Derives the picture order count of each coded picture, by LSB wrap
// detection or by sub-GOP position search, one result item per input item.
// ============================================================================
//
//   Channel   Direction  Handshake                  Payload
//   -------   ---------  -------------------------  ---------------------------
//   in        input      i_in_valid / o_in_stall    i_in_item  (pocd_pkg::t_in_item)
//   out       output     o_out_valid / i_out_stall  o_out_item (pocd_pkg::t_out_item)
//   cfg       input      i_cfg_we                   i_cfg_index, i_cfg_data
//
// LSB mode, IDR, base layer and out-of-range items go through capture,
// update and hand-off. Other sub-GOP items add a search over the sub-GOP
// positions (at most 2^MAX_LOG2_SUB_GOP) and a final add before the
// hand-off; the offset search is the longest step.
// Reset is synchronous, active low, and clears the counts to zero. A stalled
// result waits in the output register while the next item is worked on.
// ============================================================================
`default_nettype none
`include "picture_order_count_derive_core_defines.svh"

module picture_order_count_derive_core #(
    parameter int MAX_LOG2_SUB_GOP = pocd_pkg::MAX_LOG2_SUB_GOP_DEF,
    parameter int POC_WIDTH        = pocd_pkg::POC_WIDTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire pocd_pkg::t_in_item                 i_in_item,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output pocd_pkg::t_out_item                     o_out_item,
    input  wire logic                               i_cfg_we,
    input  wire logic [pocd_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  wire logic [pocd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import pocd_pkg::*;

    // Configuration registers.
    logic       r_lsb_mode;
    logic [4:0] r_log2_max_lsb;
    logic [2:0] r_log2_gop;

    // Output register.
    logic       r_out_valid;
    t_out_item  r_out;

    // Controller to datapath wiring.
    t_cmd       w_cmd;
    t_dp_status w_status;
    t_out_item  w_result;
    logic       w_ready;
    logic       w_out_free;

    // Handshake terms watched by the assertions.
    logic       w_in_take;
    logic       w_push_err;

    // The output register may take a new result when it is empty or when
    // its current result leaves in this same cycle.
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lsb_mode     <= RST_POC_LSB_MODE;
            r_log2_max_lsb <= RST_LOG2_MAX_POC_LSB;
            r_log2_gop     <= RST_LOG2_SUB_GOP_LENGTH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_POC_LSB_MODE:        r_lsb_mode     <= i_cfg_data[0];
                CFG_LOG2_MAX_POC_LSB:    r_log2_max_lsb <= i_cfg_data[4:0];
                CFG_LOG2_SUB_GOP_LENGTH: r_log2_gop     <= i_cfg_data[2:0];
                default: begin
                    // Writes to unused indexes are dropped.
                end
            endcase
        end
    end

    pocd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (w_out_free),
        .i_status   (w_status),
        .o_ready    (w_ready),
        .o_cmd      (w_cmd)
    );

    pocd_dp #(
        .MAX_LOG2_SUB_GOP (MAX_LOG2_SUB_GOP),
        .POC_WIDTH        (POC_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_item         (i_in_item),
        .i_lsb_mode     (r_lsb_mode),
        .i_log2_max_lsb (r_log2_max_lsb),
        .i_log2_gop     (r_log2_gop),
        .o_status       (w_status),
        .o_result       (w_result)
    );

    // The result register loads on a push and empties when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.push) begin
            r_out <= w_result;
        end
    end

    assign o_in_stall  = !w_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign w_in_take  = i_in_valid && !o_in_stall;
    assign w_push_err = w_cmd.push && (w_result.status == STATUS_TID_RANGE);

    // An accepted item keeps the input closed for at least the next cycle.
    `POCD_ASSERT_NEXT(a_take_closes, i_clk, i_rst_n, w_in_take, o_in_stall, "input reopened")
    // A result is only pushed into a free output register.
    `POCD_ASSERT_NOW(a_push_has_room, i_clk, i_rst_n, w_cmd.push, w_out_free, "push over a result")
    // Out-of-range status only arises in sub-GOP mode.
    `POCD_ASSERT_NOW(a_err_subgop, i_clk, i_rst_n, w_push_err, !r_lsb_mode, "error in LSB mode")
    // The controller never accepts an item while a result is being pushed.
    `POCD_ASSERT_NOW(a_push_not_load, i_clk, i_rst_n, w_cmd.push, o_in_stall, "push with input open")

endmodule

`default_nettype wire

// File: design/pocd_ctrl.sv
// ============================================================================
// pocd_ctrl
// Sequencer for one picture: capture, update or search, final add, hand-off.
// ============================================================================
`default_nettype none

module pocd_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_out_free,
    input  wire pocd_pkg::t_dp_status i_status,
    output logic                    o_ready,
    output pocd_pkg::t_cmd          o_cmd
);
    import pocd_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_CALC   = 5'b00010,
        S_SEARCH = 5'b00100,
        S_ADD    = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CALC;
                end
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = i_status.one_step ? S_DONE : S_SEARCH;
            end
            S_SEARCH: begin
                if (i_status.found) begin
                    n_state = S_ADD;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_ADD: begin
                o_cmd.finish = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// File: design/pocd_dp.sv
// ============================================================================
// pocd_dp
// POC state registers, LSB wrap logic, decode offset search and final add.
// ============================================================================
`default_nettype none

module pocd_dp #(
    parameter int MAX_LOG2_SUB_GOP = pocd_pkg::MAX_LOG2_SUB_GOP_DEF,
    parameter int POC_WIDTH        = pocd_pkg::POC_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire pocd_pkg::t_cmd       i_cmd,
    input  wire pocd_pkg::t_in_item   i_item,
    input  wire logic                 i_lsb_mode,
    input  wire logic [4:0]           i_log2_max_lsb,
    input  wire logic [2:0]           i_log2_gop,
    output pocd_pkg::t_dp_status      o_status,
    output pocd_pkg::t_out_item       o_result
);
    import pocd_pkg::*;

    localparam int OFF_W = MAX_LOG2_SUB_GOP;
    localparam int LEN_W = MAX_LOG2_SUB_GOP + 1;
    localparam int PW    = POC_WIDTH;

    // Bit length of the offset: the temporal layer expected at that position.
    function automatic logic [2:0] layer_of(input logic [OFF_W-1:0] d);
        logic [2:0] t;
        t = '0;
        for (int i = 0; i < OFF_W; i++) begin
            if (d[i]) begin
                t = 3'(i + 1);
            end
        end
        return t;
    endfunction

    // State with a defined reset.
    logic [PW-1:0]    r_cur;
    logic [PW-1:0]    r_prev;
    logic [OFF_W-1:0] r_dec;
    logic [PW-1:0]    n_cur;
    logic [PW-1:0]    n_prev;
    logic [OFF_W-1:0] n_dec;

    // Working registers of the current item.
    logic             r_idr;
    logic [15:0]      r_lsb;
    logic [2:0]       r_tid;
    logic [OFF_W-1:0] r_d;
    logic [LEN_W-1:0] r_steps;
    logic             r_status;

    // Sub-GOP geometry.
    logic [2:0]       w_lg;
    logic [LEN_W-1:0] w_len;
    logic [OFF_W-1:0] w_mask;
    logic [PW-1:0]    w_len_pw;
    logic             w_tid_over;
    logic [OFF_W-1:0] w_d0;
    logic [2:0]       w_shift;
    logic [PW-1:0]    w_off;

    // LSB mode.
    logic [4:0]       w_n;
    logic [16:0]      w_maxl;
    logic [16:0]      w_half;
    logic [16:0]      w_lmask;
    logic [16:0]      w_lsb17;
    logic [31:0]      w_cur32;
    logic [16:0]      w_plsb17;
    logic [PW-1:0]    w_pmsb;
    logic [PW-1:0]    w_maxl_pw;
    logic [PW-1:0]    w_msb;
    logic [PW-1:0]    w_lsb_poc;

    assign w_lg       = (i_log2_gop > 3'(MAX_LOG2_SUB_GOP)) ? 3'(MAX_LOG2_SUB_GOP)
                                                            : i_log2_gop;
    assign w_len      = LEN_W'(1) << w_lg;
    assign w_mask     = OFF_W'(w_len - LEN_W'(1));
    assign w_len_pw   = PW'(w_len);
    assign w_tid_over = (r_tid > w_lg);
    assign w_d0       = OFF_W'(r_dec + OFF_W'(1)) & w_mask;
    assign w_shift    = w_lg - r_tid;
    assign w_off      = (PW'({r_d, 1'b1}) << w_shift) - (w_len_pw << 1);

    assign o_status.one_step = i_lsb_mode | r_idr | w_tid_over | (r_tid == 3'd0);
    assign o_status.found    = (layer_of(r_d) == r_tid) || (r_steps == w_len);

    // LSB wrap detection against the previous count.
    always_comb begin
        priority if (i_log2_max_lsb < LSB_LOG2_MIN) begin
            w_n = LSB_LOG2_MIN;
        end else if (i_log2_max_lsb > LSB_LOG2_MAX) begin
            w_n = LSB_LOG2_MAX;
        end else begin
            w_n = i_log2_max_lsb;
        end
        w_maxl    = 17'(1) << w_n;
        w_half    = w_maxl >> 1;
        w_lmask   = w_maxl - 17'd1;
        w_lsb17   = r_idr ? 17'd0 : ({1'b0, r_lsb} & w_lmask);
        w_cur32   = 32'(signed'(r_cur));
        w_plsb17  = w_cur32[16:0] & w_lmask;
        w_pmsb    = r_cur - PW'(w_plsb17);
        w_maxl_pw = PW'(w_maxl);
        priority if (r_idr) begin
            w_msb = '0;
        end else if ((w_lsb17 < w_plsb17) && ((w_plsb17 - w_lsb17) >= w_half)) begin
            w_msb = w_pmsb + w_maxl_pw;
        end else if ((w_lsb17 > w_plsb17) && ((w_lsb17 - w_plsb17) > w_half)) begin
            w_msb = w_pmsb - w_maxl_pw;
        end else begin
            w_msb = w_pmsb;
        end
        w_lsb_poc = w_msb + PW'(w_lsb17);
    end

    // Next values of the persistent counts.
    always_comb begin
        n_cur  = r_cur;
        n_prev = r_prev;
        n_dec  = r_dec;
        if (i_cmd.calc) begin
            priority if (i_lsb_mode) begin
                n_prev = r_cur;
                n_cur  = w_lsb_poc;
            end else if (r_idr) begin
                n_cur  = '0;
                n_prev = '0;
                n_dec  = '1;
            end else if (w_tid_over) begin
                n_cur = r_cur;
            end else if (r_tid == 3'd0) begin
                n_cur  = r_prev + w_len_pw;
                n_prev = r_prev + w_len_pw;
                n_dec  = '0;
            end else if (w_d0 == '0) begin
                n_prev = r_prev + w_len_pw;
            end else begin
                n_prev = r_prev;
            end
        end
        if (i_cmd.finish) begin
            n_dec = r_d;
            n_cur = r_prev + w_off;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur  <= '0;
            r_prev <= '0;
            r_dec  <= '0;
        end else begin
            r_cur  <= n_cur;
            r_prev <= n_prev;
            r_dec  <= n_dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_idr <= i_item.is_idr;
            r_lsb <= i_item.poc_lsb;
            r_tid <= i_item.temporal_id;
        end
        if (i_cmd.calc) begin
            r_status <= (!i_lsb_mode && !r_idr && w_tid_over) ? STATUS_TID_RANGE
                                                              : STATUS_OK;
            r_d      <= w_d0;
            r_steps  <= '0;
        end
        if (i_cmd.step) begin
            r_d     <= OFF_W'(r_d + OFF_W'(1)) & w_mask;
            r_steps <= r_steps + LEN_W'(1);
        end
    end

    assign o_result.poc_value = 32'(signed'(r_cur));
    assign o_result.status    = r_status;

endmodule

`default_nettype wire
